@@ sv/grdd_pkg.sv @@
`timescale 1ns / 1ps
package grdd_pkg;

  localparam int MAP_DIM_DEF   = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_STEPS_DEF = 128;

  localparam int POS_W   = 22;
  localparam int VEC_W   = 18;
  localparam int CELL_W  = 6;
  localparam int DIST_W  = 32;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] REG_POS_X   = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_POS_Y   = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_PLANE_Y = 3'd5;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CAST  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_RAY,
    ST_DIV,
    ST_SIDE,
    ST_STEP,
    ST_READ,
    ST_TEST,
    ST_DONE
  } grdd_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic mul;
    logic ray;
    logic div_start;
    logic side;
    logic step;
    logic test;
    logic finish;
  } grdd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
    logic out_of_map;
    logic wall;
    logic last_step;
  } grdd_stat_t;

endpackage

@@ sv/grdd_ctrl.sv @@
`timescale 1ns / 1ps
module grdd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                req_type,
  input  grdd_pkg::grdd_stat_t stat,
  output grdd_pkg::grdd_cmd_t  cmd,
  output logic                busy
);
  import grdd_pkg::*;

  grdd_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (req_type == REQ_CAST) state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RAY;
      end
      ST_RAY: begin
        cmd.ray   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_SIDE;
      end
      ST_SIDE: begin
        if (stat.div_done) begin
          cmd.side  = 1'b1;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (stat.out_of_map || stat.wall || stat.last_step) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.test  = 1'b1;
          state_nxt = ST_STEP;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  a_done_from_test: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> $past(state_r) == ST_TEST)
    else $error("done not entered from test");
  a_side_waits_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.side |-> stat.div_done)
    else $error("side computed before division done");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> $past(state_r) != ST_IDLE || state_r == ST_IDLE)
    else $error("load outside idle");

endmodule

@@ sv/grdd_div.sv @@
`timescale 1ns / 1ps
// Restoring divider: computes floor(2^(2F) / den), one quotient bit a cycle.
module grdd_div #(
  parameter int FRAC_BITS = grdd_pkg::FRAC_BITS_DEF,
  parameter int DEN_W     = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DEN_W-1:0]       den,
  output logic                   done,
  output logic [2*FRAC_BITS:0]   quo
);
  localparam int NB  = 2 * FRAC_BITS + 1;
  localparam int CW  = $clog2(NB + 1);

  logic [NB-1:0]    num_r, num_nxt;
  logic [NB-1:0]    quo_r, quo_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DEN_W:0]   trial;

  // One quotient bit per cycle.
  always_comb begin
    num_nxt = num_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r[DEN_W-1:0], num_r[NB-1]};
    if (start) begin
      num_nxt = {1'b1, {(NB-1){1'b0}}};
      quo_nxt = '0;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CW'(NB);
    end else if (cnt_r != '0) begin
      num_nxt = {num_r[NB-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[NB-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = (cnt_r == '0) && !start;
  assign quo  = quo_r;

endmodule

@@ sv/grdd_dpath.sv @@
`timescale 1ns / 1ps
module grdd_dpath #(
  parameter int MAX_STEPS = grdd_pkg::MAX_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  grdd_pkg::grdd_cmd_t                 cmd,
  output grdd_pkg::grdd_stat_t                stat,
  input  logic                                cfg_we,
  input  logic [grdd_pkg::CFG_A_W-1:0]        cfg_addr,
  input  logic [grdd_pkg::CFG_D_W-1:0]        cfg_data,
  input  logic                                req_type,
  input  logic [grdd_pkg::CELL_W-1:0]         cell_x,
  input  logic [grdd_pkg::CELL_W-1:0]         cell_y,
  input  logic                                cell_is_wall,
  input  logic signed [grdd_pkg::VEC_W-1:0]   camera_offset,
  output logic                                out_valid,
  output logic [grdd_pkg::DIST_W-1:0]         wall_distance,
  output logic                                hit_side,
  output logic [grdd_pkg::CELL_W-1:0]         hit_cell_x,
  output logic [grdd_pkg::CELL_W-1:0]         hit_cell_y,
  output logic                                ray_lost
);
  import grdd_pkg::*;

  localparam int MAP_DIM   = MAP_DIM_DEF;
  localparam int FRAC_BITS = FRAC_BITS_DEF;
  localparam int MB    = $clog2(MAP_DIM);
  localparam int IB    = MB + 2;
  localparam int PW    = 2 * VEC_W;
  localparam int RW    = VEC_W + 2;
  localparam int QW    = 2 * FRAC_BITS + 1;
  localparam int SW    = 64;
  localparam int NW    = $clog2(MAX_STEPS + 1);
  localparam logic [SW-1:0] DMAX  = SW'(64'hFFFF_FFFF);
  localparam logic [SW-1:0] NUDGE = SW'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Configuration registers.
  logic [POS_W-1:0]        pos_x_r, pos_y_r;
  logic signed [VEC_W-1:0] dir_x_r, dir_y_r, pl_x_r, pl_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      dir_x_r <= VEC_W'(65536);
      dir_y_r <= '0;
      pl_x_r  <= '0;
      pl_y_r  <= VEC_W'(43690);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_POS_X:   pos_x_r <= cfg_data[POS_W-1:0];
        REG_POS_Y:   pos_y_r <= cfg_data[POS_W-1:0];
        REG_DIR_X:   dir_x_r <= cfg_data[VEC_W-1:0];
        REG_DIR_Y:   dir_y_r <= cfg_data[VEC_W-1:0];
        REG_PLANE_X: pl_x_r  <= cfg_data[VEC_W-1:0];
        REG_PLANE_Y: pl_y_r  <= cfg_data[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Wall map memory, written by write beats and read one cell per step.
  logic wall_map [MAP_DIM*MAP_DIM];
  logic rd_bit_r;
  logic signed [IB-1:0] cx_r, cy_r;
  logic in_map;

  always_ff @(posedge clk) begin
    if (cmd.load && req_type == REQ_WRITE &&
        {2'b0, cell_x} < 8'(MAP_DIM) && {2'b0, cell_y} < 8'(MAP_DIM)) begin
      wall_map[{cell_x[MB-1:0], cell_y[MB-1:0]}] <= cell_is_wall;
    end
    rd_bit_r <= wall_map[{cx_r[MB-1:0], cy_r[MB-1:0]}];
  end

  // Camera product, then ray vector.
  logic signed [VEC_W-1:0] cam_r;
  logic signed [PW-1:0]    px_r, py_r;
  logic signed [RW-1:0]    ray_x_r, ray_y_r;
  logic signed [PW-1:0]    shx, shy;

  always_ff @(posedge clk) begin
    if (cmd.load) cam_r <= camera_offset;
    if (cmd.mul) begin
      px_r <= pl_x_r * cam_r;
      py_r <= pl_y_r * cam_r;
    end
    if (cmd.ray) begin
      ray_x_r <= RW'(dir_x_r) + RW'(shx);
      ray_y_r <= RW'(dir_y_r) + RW'(shy);
    end
  end
  assign shx = px_r >>> FRAC_BITS;
  assign shy = py_r >>> FRAC_BITS;

  // Two reciprocals run side by side.
  logic [RW-1:0] abs_x, abs_y;
  logic [QW-1:0] qx, qy;
  logic          dnx, dny;
  assign abs_x = ray_x_r[RW-1] ? RW'(-ray_x_r) : RW'(ray_x_r);
  assign abs_y = ray_y_r[RW-1] ? RW'(-ray_y_r) : RW'(ray_y_r);

  grdd_div #(.FRAC_BITS(FRAC_BITS), .DEN_W(RW)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .den(abs_x),
    .done(dnx), .quo(qx));
  grdd_div #(.FRAC_BITS(FRAC_BITS), .DEN_W(RW)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .den(abs_y),
    .done(dny), .quo(qy));

  // Saturated delta per axis.
  logic [SW-1:0] dlx, dly;
  always_comb begin
    dlx = (abs_x == '0 || SW'(qx) > DMAX) ? DMAX : SW'(qx);
    dly = (abs_y == '0 || SW'(qy) > DMAX) ? DMAX : SW'(qy);
  end

  // Initial side distances and stepping.
  logic [SW-1:0]        dx_r, dy_r, sdx_r, sdy_r;
  logic                 side_r;
  logic [NW-1:0]        n_r;
  logic [FRAC_BITS:0]   fx, fy;
  logic [FRAC_BITS-1:0] frx, fry;
  logic [SW-1:0]        prx, pry;

  assign frx = pos_x_r[FRAC_BITS-1:0];
  assign fry = pos_y_r[FRAC_BITS-1:0];
  assign fx  = ray_x_r[RW-1] ? {1'b0, frx} : ONE - {1'b0, frx};
  assign fy  = ray_y_r[RW-1] ? {1'b0, fry} : ONE - {1'b0, fry};
  assign prx = SW'(fx) * dlx;
  assign pry = SW'(fy) * dly;

  always_ff @(posedge clk) begin
    if (cmd.side) begin
      dx_r   <= dlx;
      dy_r   <= dly;
      sdx_r  <= prx >> FRAC_BITS;
      sdy_r  <= pry >> FRAC_BITS;
      cx_r   <= IB'(pos_x_r >> FRAC_BITS);
      cy_r   <= IB'(pos_y_r >> FRAC_BITS);
      n_r    <= '0;
    end else if (cmd.step) begin
      n_r <= n_r + 1'b1;
      if (sdx_r < sdy_r) begin
        sdx_r  <= sdx_r + dx_r;
        cx_r   <= ray_x_r[RW-1] ? cx_r - 1'b1 : cx_r + 1'b1;
        side_r <= 1'b0;
      end else begin
        sdy_r  <= sdy_r + dy_r;
        cy_r   <= ray_y_r[RW-1] ? cy_r - 1'b1 : cy_r + 1'b1;
        side_r <= 1'b1;
      end
    end
  end

  assign in_map = !cx_r[IB-1] && !cy_r[IB-1] &&
                  cx_r < IB'(MAP_DIM) && cy_r < IB'(MAP_DIM);

  assign stat.div_done   = dnx && dny;
  assign stat.out_of_map = !in_map;
  assign stat.wall       = in_map && rd_bit_r;
  assign stat.last_step  = (n_r == NW'(MAX_STEPS));

  // Result register.
  logic [SW-1:0] dist_sum;
  assign dist_sum = (side_r ? sdy_r - dy_r : sdx_r - dx_r) + NUDGE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
    end
    if (cmd.finish) begin
      if (stat.wall) begin
        wall_distance <= (dist_sum > DMAX) ? DIST_W'(DMAX) : DIST_W'(dist_sum);
        hit_side      <= side_r;
        hit_cell_x    <= CELL_W'(cx_r);
        hit_cell_y    <= CELL_W'(cy_r);
        ray_lost      <= 1'b0;
      end else begin
        wall_distance <= '0;
        hit_side      <= 1'b0;
        hit_cell_x    <= '0;
        hit_cell_y    <= '0;
        ray_lost      <= 1'b1;
      end
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> n_r < NW'(MAX_STEPS))
    else $error("step past limit");
  a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result longer than one cycle");
  a_lost_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ray_lost |-> wall_distance == '0)
    else $error("lost ray carries distance");

endmodule

@@ sv/grid_ray_wall_distance.sv @@
`timescale 1ns / 1ps
// Grid raycaster. A write beat stores one wall bit in the cycle it is taken
// and leaves busy low, so writes can follow back to back. A cast beat keeps
// busy high through the setup states (camera product, ray vector, divider
// start), while the two bit-serial reciprocal dividers run side by side,
// through each of up to MAX_STEPS cell steps (step, map read, test) and
// while the result is registered. Exactly one result per cast on out_valid
// for one cycle, the first cycle with busy low again; the receiver cannot
// stall, so results must be taken when shown. Write the map before casting.
module grid_ray_wall_distance #(
  parameter int MAX_STEPS = grdd_pkg::MAX_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_req_type,
  input  logic [grdd_pkg::CELL_W-1:0]       in_cell_x,
  input  logic [grdd_pkg::CELL_W-1:0]       in_cell_y,
  input  logic                              in_cell_is_wall,
  input  logic signed [grdd_pkg::VEC_W-1:0] in_camera_offset,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [grdd_pkg::CFG_A_W-1:0]      cfg_addr,
  input  logic [grdd_pkg::CFG_D_W-1:0]      cfg_data,
  output logic                              out_valid,
  output logic [grdd_pkg::DIST_W-1:0]       out_wall_distance,
  output logic                              out_hit_side,
  output logic [grdd_pkg::CELL_W-1:0]       out_hit_cell_x,
  output logic [grdd_pkg::CELL_W-1:0]       out_hit_cell_y,
  output logic                              out_ray_lost
);
  import grdd_pkg::*;

  grdd_cmd_t  cmd;
  grdd_stat_t stat;

  assign cfg_ready = 1'b1;

  grdd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .req_type(in_req_type),
    .stat(stat), .cmd(cmd), .busy(busy));

  grdd_dpath #(.MAX_STEPS(MAX_STEPS)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_valid && cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .req_type(in_req_type), .cell_x(in_cell_x), .cell_y(in_cell_y),
    .cell_is_wall(in_cell_is_wall), .camera_offset(in_camera_offset),
    .out_valid(out_valid), .wall_distance(out_wall_distance),
    .hit_side(out_hit_side), .hit_cell_x(out_hit_cell_x),
    .hit_cell_y(out_hit_cell_y), .ray_lost(out_ray_lost));

  a_busy_after_cast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == REQ_CAST |=> busy)
    else $error("cast not taken");

endmodule
